/* hw/rtl/software_timer_table_assert.svh */
// ----------------------------------------------------------------------------
// software_timer_table_assert
// Assertion macros shared by the timer table RTL.
// ----------------------------------------------------------------------------
`ifndef SOFTWARE_TIMER_TABLE_ASSERT_SVH
`define SOFTWARE_TIMER_TABLE_ASSERT_SVH
// Implication checked on every edge outside reset.
`define STT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Implication checked in the cycle after the antecedent.
`define STT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

/* hw/rtl/stt_pkg.sv */
// ----------------------------------------------------------------------------
// stt_pkg
// Types and codes shared by the timer table modules.
// ----------------------------------------------------------------------------
package stt_pkg;
  localparam int TimeW = 48;
  localparam logic [TimeW-1:0] TimeMax = {TimeW{1'b1}};

  typedef logic [1:0] op_t;
  localparam op_t OpAdd    = 2'd0;
  localparam op_t OpCancel = 2'd1;
  localparam op_t OpTick   = 2'd2;

  typedef logic [2:0] status_t;
  localparam status_t StAdded   = 3'd0;
  localparam status_t StDup     = 3'd1;
  localparam status_t StFull    = 3'd2;
  localparam status_t StCancel  = 3'd3;
  localparam status_t StMissing = 3'd4;
  localparam status_t StTick    = 3'd5;

  typedef struct packed {
    logic [7:0]       id;
    logic [TimeW-1:0] due;
    logic [31:0]      period;
  } entry_t;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic       load;     // write the broadcast entry at the tail
    logic       shift;    // take the right neighbor's entry
  } cell_ctl_t;
endpackage

/* hw/rtl/stt_cell.sv */
// ----------------------------------------------------------------------------
// stt_cell
// One table slot: holds an entry and can take its neighbor's entry.
// ----------------------------------------------------------------------------
module stt_cell (
  input  logic               clk,
  input  stt_pkg::cell_ctl_t ctl,
  input  logic               sel_load,
  input  logic               sel_shift,
  input  stt_pkg::entry_t    nbr,
  input  stt_pkg::entry_t    load_entry,
  output stt_pkg::entry_t    q
);
  import stt_pkg::*;

  always_ff @(posedge clk) begin
    if (ctl.load && sel_load) begin
      q <= load_entry;
    end else if (ctl.shift && sel_shift) begin
      q <= nbr;
    end
  end
endmodule

/* hw/rtl/software_timer_table.sv */
// ----------------------------------------------------------------------------
// software_timer_table
// Ordered timer list held in a row of shifting cells.
// ----------------------------------------------------------------------------
// Entries sit in a chain of SLOTS cells, cell 0 at the head. Add writes the
// tail straight from idle, so the next beat can follow on the next cycle
// unless the output is stalled. Cancel and tick walk the chain: on each step
// the head entry leaves and re-enters behind the entries still to be visited
// (or is dropped), so either stalls the input through the walk, the step that
// ends it and the done state that posts the final beat.
// Results leave through a one-entry output register; the walk waits while a
// result is stalled, and a tick holds back each report by one step so the
// final one can carry last.
module software_timer_table #(
  parameter int SLOTS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  stt_pkg::op_t             operation,
  input  logic [7:0]               event_id,
  input  logic [stt_pkg::TimeW-1:0] now_time,
  input  logic [31:0]              first_delay,
  input  logic [31:0]              interval,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [7:0]               event_id_res,
  output logic                     fired,
  output stt_pkg::status_t         status,
  output logic                     last
);
  import stt_pkg::*;
  `include "software_timer_table_assert.svh"

  localparam int CntW = $clog2(SLOTS + 1);
  localparam int IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int RepMax = 16;

  typedef enum logic [1:0] {SIdle, SWalk, SDone} state_t;
  state_t state;

  entry_t    cells [SLOTS];
  entry_t    nbrs  [SLOTS];
  cell_ctl_t ctl;
  logic [SLOTS-1:0] sel_load, sel_shift;

  logic [CntW-1:0] count, remain, kept;
  logic [4:0]      nrep;
  op_t             op;
  logic [7:0]      key;
  logic [TimeW-1:0] now_r;
  logic            found, pend_last;
  logic [7:0]      pend_id;
  entry_t          load_entry, head_new;
  logic            head_keep, head_rep;
  logic [TimeW:0]  adv_sum;
  logic [TimeW:0]  add_sum;

  assign in_stall = (state != SIdle) || (out_valid && out_stall);
  wire acc = in_valid && !in_stall;
  wire step = (state == SWalk) && (remain != '0) && !(out_valid && out_stall);

  // Head entry decision during a walk.
  always_comb begin
    adv_sum = {1'b0, cells[0].due} + {{(TimeW-31){1'b0}}, cells[0].period};
    head_new = cells[0];
    head_keep = 1'b1;
    head_rep = 1'b0;
    if (op == OpCancel) begin
      if (!found && cells[0].id == key) head_keep = 1'b0;
    end else if (cells[0].due <= now_r && nrep < 5'(RepMax)) begin
      head_rep = 1'b1;
      if (cells[0].period == '0) head_keep = 1'b0;
      else head_new.due = adv_sum[TimeW] ? TimeMax : adv_sum[TimeW-1:0];
    end
  end

  // The tail slot for re-entry is the one just past the kept entries after
  // the shift; the chain shifts left across all cells on each step.
  always_comb begin
    ctl = '0;
    ctl.load = (acc && operation == OpAdd) || (step && head_keep);
    ctl.shift = step;
    sel_load = '0;
    sel_shift = '0;
    load_entry = head_new;
    add_sum = {1'b0, now_time} + {{(TimeW-31){1'b0}}, first_delay};
    for (int i = 0; i < SLOTS; i++) begin
      nbrs[i] = cells[(i + 1 < SLOTS) ? i + 1 : i];
      if (step) sel_shift[i] = 1'b1;
    end
    if (state == SIdle) begin
      load_entry.id = event_id;
      load_entry.due = add_sum[TimeW] ? TimeMax : add_sum[TimeW-1:0];
      load_entry.period = interval;
      if (count < CntW'(SLOTS)) sel_load[count[IdxW-1:0]] = 1'b1;
    end else begin
      // Entry lands behind the not-yet-visited ones and the kept ones.
      sel_load[IdxW'(CntW'(remain - 1'b1) + kept)] = 1'b1;
    end
  end

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    stt_cell u_cell (
      .clk(clk), .ctl(ctl), .sel_load(sel_load[g]), .sel_shift(sel_shift[g]),
      .nbr(nbrs[g]), .load_entry(load_entry), .q(cells[g])
    );
  end

  logic dup;
  always_comb begin
    dup = 1'b0;
    for (int i = 0; i < SLOTS; i++)
      if (CntW'(i) < count && cells[i].id == event_id) dup = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SIdle;
      count <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        SIdle: if (acc) begin
          op <= operation; key <= event_id; now_r <= now_time;
          found <= 1'b0; nrep <= '0; kept <= '0; remain <= count;
          pend_last <= 1'b0;
          if (operation == OpAdd) begin
            out_valid <= 1'b1; event_id_res <= event_id; fired <= 1'b0;
            last <= 1'b1;
            if (dup) status <= StDup;
            else if (count >= CntW'(SLOTS)) status <= StFull;
            else begin
              status <= StAdded;
              count <= count + 1'b1;
            end
          end else if (operation == OpCancel || operation == OpTick) begin
            state <= SWalk;
          end
        end
        SWalk: begin
          if (step) begin
            remain <= remain - 1'b1;
            if (head_keep) kept <= kept + 1'b1;
            if (op == OpCancel && !head_keep) found <= 1'b1;
            if (head_rep) begin
              // Hold each report one step so the final one can carry last.
              nrep <= nrep + 1'b1;
              pend_id <= cells[0].id;
              pend_last <= 1'b1;
              if (pend_last) begin
                out_valid <= 1'b1; event_id_res <= pend_id;
                fired <= 1'b1; status <= StTick; last <= 1'b0;
              end
            end
          end else if (remain == '0 && !(out_valid && out_stall)) begin
            state <= SDone;
          end
        end
        SDone: if (!(out_valid && out_stall)) begin
          count <= kept;
          state <= SIdle;
          if (op == OpCancel) begin
            out_valid <= 1'b1; event_id_res <= key; fired <= 1'b0; last <= 1'b1;
            status <= found ? StCancel : StMissing;
          end else if (pend_last) begin
            out_valid <= 1'b1; event_id_res <= pend_id; fired <= 1'b1;
            status <= StTick; last <= 1'b1;
          end
        end
        default: state <= SIdle;
      endcase
    end
  end

  `STT_ASSERT_IMP(a_count_range, 1'b1, count <= CntW'(SLOTS))
  `STT_ASSERT_NEXT(a_add_one_cycle, acc && operation == OpAdd, out_valid && last)
  `STT_ASSERT_IMP(a_busy_stalls, state != SIdle, in_stall)
endmodule

/* tb/sv/software_timer_table_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// software_timer_table_tb
// Self-checking bench for the ordered timer table.
// ----------------------------------------------------------------------------
// A behavioral timer list predicts the beats of every add, cancel and tick.
// Directed cases cover duplicates, a full table, saturation, late periodic
// timers, the report limit and one long output hold-off; random sequences
// follow, with bursty input and random output stalls.
// ----------------------------------------------------------------------------
module software_timer_table_tb;
  import stt_pkg::*;

  localparam int Slots = 16;
  localparam int MaxReports = 16;
  localparam op_t OpUnknown = 2'd3;

  typedef struct packed {
    logic [7:0] id;
    logic       fired;
    status_t    status;
    logic       last;
  } report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  op_t operation = OpAdd;
  logic [7:0] event_id = '0;
  logic [TimeW-1:0] now_time = '0;
  logic [31:0] first_delay = '0;
  logic [31:0] interval = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] event_id_res;
  logic fired;
  status_t status;
  logic last;

  software_timer_table #(.SLOTS(Slots)) dut (.*);

  // Predicted timer list.
  logic [7:0] list_id[Slots];
  logic [TimeW-1:0] list_due[Slots];
  logic [31:0] list_period[Slots];
  int list_count = 0;
  report_t pending_reports[$];
  int errors = 0;
  bit hold_off = 1'b0;
  bit burst_mode = 1'b1;
  logic [TimeW-1:0] clock_now = '0;

  initial forever #4 clk = ~clk;

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic logic [TimeW-1:0] due_sum(logic [TimeW-1:0] a, logic [31:0] b);
    logic [TimeW:0] s;
    s = {1'b0, a} + {{(TimeW-31){1'b0}}, b};
    return s[TimeW] ? TimeMax : s[TimeW-1:0];
  endfunction

  function automatic int find_timer(logic [7:0] id);
    for (int k = 0; k < list_count; k++) if (list_id[k] == id) return k;
    return -1;
  endfunction

  function automatic void push_report(logic [7:0] id, logic f, status_t st, logic l);
    report_t r;
    r.id = id; r.fired = f; r.status = st; r.last = l;
    pending_reports = {pending_reports, r};
  endfunction

  function automatic void predict_timers(op_t op, logic [7:0] id, logic [TimeW-1:0] now,
                                         logic [31:0] delay, logic [31:0] ival);
    int pos, n, w;
    bit drop[Slots];
    case (op)
      OpAdd: begin
        if (find_timer(id) >= 0) push_report(id, 1'b0, StDup, 1'b1);
        else if (list_count >= Slots) push_report(id, 1'b0, StFull, 1'b1);
        else begin
          list_id[list_count] = id;
          list_due[list_count] = due_sum(now, delay);
          list_period[list_count] = ival;
          list_count++;
          push_report(id, 1'b0, StAdded, 1'b1);
        end
      end
      OpCancel: begin
        pos = find_timer(id);
        if (pos < 0) push_report(id, 1'b0, StMissing, 1'b1);
        else begin
          for (int k = pos; k + 1 < list_count; k++) begin
            list_id[k] = list_id[k+1];
            list_due[k] = list_due[k+1];
            list_period[k] = list_period[k+1];
          end
          list_count--;
          push_report(id, 1'b0, StCancel, 1'b1);
        end
      end
      OpTick: begin
        n = 0;
        w = 0;
        for (int k = 0; k < list_count; k++) begin
          drop[k] = 1'b0;
          if (list_due[k] > now || n >= MaxReports) continue;
          push_report(list_id[k], 1'b1, StTick, 1'b0);
          n++;
          if (list_period[k] != 0) list_due[k] = due_sum(list_due[k], list_period[k]);
          else drop[k] = 1'b1;
        end
        for (int k = 0; k < list_count; k++) begin
          if (drop[k]) continue;
          list_id[w] = list_id[k];
          list_due[w] = list_due[k];
          list_period[w] = list_period[k];
          w++;
        end
        list_count = w;
        if (n > 0) pending_reports[$].last = 1'b1;
      end
      default: ;
    endcase
  endfunction

  // Sends one beat, honoring the burst gaps. Valid stays high after the
  // beat so that the next call can follow back to back.
  task automatic send_command(op_t op, logic [7:0] id, logic [TimeW-1:0] now,
                              logic [31:0] delay, logic [31:0] ival);
    if (!burst_mode && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    operation <= op;
    event_id <= id;
    now_time <= now;
    first_delay <= delay;
    interval <= ival;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    predict_timers(op, id, now, delay, ival);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(negedge clk);
    repeat (Slots + 6) @(negedge clk);
  endtask

  // Result checker.
  always @(posedge clk) begin
    report_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_reports.size() == 0) begin
        $display("%0t: expected no beat, got id=%0d status=%0d", $time, event_id_res, status);
        errors++;
      end else begin
        want = pending_reports.pop_front();
        if (want != {event_id_res, fired, status, last}) begin
          $display("%0t: expected id=%0d fired=%0d status=%0d last=%0d,",
                   $time, want.id, want.fired, want.status, want.last);
          $display("%0t: got id=%0d fired=%0d status=%0d last=%0d",
                   $time, event_id_res, fired, status, last);
          errors++;
        end
      end
    end
  end

  // Output stall pattern, with an occasional long hold-off.
  initial begin
    int phase = 0;
    forever begin
      @(negedge clk);
      phase++;
      if (hold_off) out_stall <= 1'b1;
      else if (phase % 200 < 60) out_stall <= 1'b0;
      else out_stall <= ($urandom_range(0, 2) == 0);
    end
  end

  task automatic test_add_and_duplicate();
    send_command(OpAdd, 8'd0, '0, 32'd10, 32'd0);
    send_command(OpAdd, 8'd255, '0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_command(OpAdd, 8'd0, '0, 32'd5, 32'd5);
    send_command(OpCancel, 8'd7, '0, '0, '0);
    send_command(OpCancel, 8'd0, '0, '0, '0);
    send_command(OpTick, 8'd0, '0, '0, '0);
    send_command(OpUnknown, 8'hAA, TimeMax, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_command(OpCancel, 8'd255, '0, '0, '0);
    drain_results();
  endtask

  task automatic test_full_and_saturation();
    for (int k = 0; k < Slots; k++)
      send_command(OpAdd, 8'(k + 1), TimeMax - 48'd3, 32'(k * 2), 32'(k % 3));
    send_command(OpAdd, 8'd200, '0, '0, '0);
    send_command(OpAdd, 8'd3, '0, '0, '0);
    // Every timer is due; periodic ones saturate and stay due.
    send_command(OpTick, '0, TimeMax, '0, '0);
    send_command(OpTick, '0, TimeMax, '0, '0);
    send_command(OpTick, '0, '0, '0, '0);
    for (int k = 1; k <= Slots; k++) send_command(OpCancel, 8'(k), '0, '0, '0);
    drain_results();
  endtask

  task automatic test_late_periodic();
    send_command(OpAdd, 8'd9, 48'd100, 32'd0, 32'd10);
    send_command(OpTick, '0, 48'd1000, '0, '0);
    send_command(OpTick, '0, 48'd1000, '0, '0);
    send_command(OpCancel, 8'd9, '0, '0, '0);
    drain_results();
  endtask

  // The output is held off while the input keeps offering beats.
  task automatic test_output_backpressure();
    hold_off = 1'b1;
    fork
      begin
        repeat (150) @(negedge clk);
        hold_off = 1'b0;
      end
      begin
        for (int k = 0; k < 12; k++)
          send_command(OpAdd, 8'(40 + k), '0, 32'(k), 32'(k & 1));
        send_command(OpTick, '0, 48'd20, '0, '0);
      end
    join
    drain_results();
  endtask

  task automatic test_random_sequences();
    logic [7:0] id;
    int sel;
    burst_mode = 1'b0;
    for (int n = 0; n < 218; n++) begin
      if (n % 40 == 0) burst_mode = ~burst_mode;
      clock_now = clock_now + 48'($urandom_range(0, 300));
      if ($urandom_range(0, 19) == 0) clock_now = 48'({$urandom(), $urandom()});
      id = (n % 3 == 0) ? 8'($urandom()) : 8'($urandom_range(0, 23));
      sel = $urandom_range(0, 19);
      if (sel < 9)
        send_command(OpAdd, id, clock_now,
                     ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 600),
                     ($urandom_range(0, 2) == 0) ? 32'd0 :
                     ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(1, 400));
      else if (sel < 13) send_command(OpCancel, id, '0, $urandom(), $urandom());
      else if (sel < 19) send_command(OpTick, id, clock_now, $urandom(), $urandom());
      else send_command(OpUnknown, id, 48'({$urandom(), $urandom()}), $urandom(),
                        $urandom());
    end
    drain_results();
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    test_add_and_duplicate();
    test_full_and_saturation();
    test_late_periodic();
    test_output_backpressure();
    test_random_sequences();
    if (errors == 0 && pending_reports.size() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
